FILE: rtl/rcd_pkg.sv
// Shared types, codes and helpers of the ring cadence detector.
`timescale 1ns / 1ps
package rcd_pkg;

	localparam int CNT_BITS   = 8;
	localparam int CMP_W      = (CNT_BITS > 8) ? CNT_BITS : 8;
	localparam int ELAPSED_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_BITS-1:0]  CNT_MAX     = '1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_LOW,
		PH_HIGH,
		PH_IDLE
	} rcd_phase_t;

	typedef enum logic [1:0] {
		ST_SEARCH,
		ST_FOUND,
		ST_TIMEOUT,
		ST_IDLE
	} rcd_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_MIN,
		CFG_LOW_MAX,
		CFG_HIGH_MIN,
		CFG_HIGH_MAX,
		CFG_RING_TARGET,
		CFG_WINDOW_TICKS
	} rcd_cfg_idx_t;

	typedef struct packed {
		logic line_level;
		logic restart;
	} rcd_sample_t;

	typedef struct packed {
		rcd_status_t status;
		logic [7:0]  ring_tally;
	} rcd_result_t;

	typedef struct packed {
		logic [7:0]  low_min;
		logic [7:0]  low_max;
		logic [7:0]  high_min;
		logic [7:0]  high_max;
		logic [7:0]  ring_target;
		logic [15:0] window_ticks;
	} rcd_cfg_t;

	typedef struct packed {
		rcd_phase_t            phase;
		logic                  prev_level;
		logic [CNT_BITS-1:0]   low_count;
		logic [CNT_BITS-1:0]   high_count;
		logic [CNT_BITS-1:0]   valid_rings;
		logic [ELAPSED_W-1:0]  elapsed;
	} rcd_state_t;

	localparam rcd_cfg_t CFG_RESET = '{
		low_min:      8'd7,
		low_max:      8'd9,
		high_min:     8'd15,
		high_max:     8'd19,
		ring_target:  8'd3,
		window_ticks: 16'd100
	};

	localparam rcd_state_t STATE_RESET = '{
		phase:       PH_IDLE,
		prev_level:  1'b1,
		low_count:   '0,
		high_count:  '0,
		valid_rings: '0,
		elapsed:     '0
	};

	function automatic logic [CNT_BITS-1:0] sat_cnt(input logic [CNT_BITS-1:0] v);
		return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
	endfunction

	function automatic logic [ELAPSED_W-1:0] sat_elapsed(input logic [ELAPSED_W-1:0] v);
		return (v < ELAPSED_MAX) ? v + 1'b1 : ELAPSED_MAX;
	endfunction

	function automatic logic in_window(input logic [CMP_W-1:0] v,
			input logic [CMP_W-1:0] lo, input logic [CMP_W-1:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

endpackage

FILE: rtl/rcd_step.sv
// Next-state and result logic for one sampled line level.
`timescale 1ns / 1ps
module rcd_step (
	input  rcd_pkg::rcd_cfg_t    cfg,
	input  rcd_pkg::rcd_state_t  cur,
	input  rcd_pkg::rcd_sample_t sample,
	output rcd_pkg::rcd_state_t  nxt,
	output rcd_pkg::rcd_result_t result
);
	import rcd_pkg::*;

	logic judged_valid;
	logic low_ok;
	logic high_ok;

	assign low_ok = in_window(CMP_W'(cur.low_count), CMP_W'(cfg.low_min),
		CMP_W'(cfg.low_max));
	assign high_ok = in_window(CMP_W'(cur.high_count), CMP_W'(cfg.high_min),
		CMP_W'(cfg.high_max));

	always_comb begin
		nxt          = cur;
		judged_valid = 1'b0;
		result.status     = ST_SEARCH;
		result.ring_tally = 8'(cur.valid_rings);
		if (sample.restart) begin
			nxt.phase       = PH_WAIT;
			nxt.low_count   = '0;
			nxt.high_count  = '0;
			nxt.valid_rings = '0;
			nxt.elapsed     = '0;
			nxt.prev_level  = sample.line_level;
			result.ring_tally = '0;
		end else if (cur.phase == PH_IDLE) begin
			nxt.prev_level = sample.line_level;
			result.status  = ST_IDLE;
		end else begin
			nxt.elapsed = sat_elapsed(cur.elapsed);
			case (cur.phase)
				PH_WAIT: begin
					if (cur.prev_level && !sample.line_level) begin
						nxt.phase      = PH_LOW;
						nxt.low_count  = CNT_BITS'(1);
						nxt.high_count = '0;
					end
				end
				PH_LOW: begin
					if (!sample.line_level) begin
						nxt.low_count = sat_cnt(cur.low_count);
					end else if (low_ok) begin
						nxt.phase      = PH_HIGH;
						nxt.high_count = CNT_BITS'(1);
					end else begin
						nxt.valid_rings = '0;
						nxt.phase       = PH_WAIT;
					end
				end
				PH_HIGH: begin
					if (sample.line_level) begin
						nxt.high_count = sat_cnt(cur.high_count);
					end else begin
						if (high_ok) begin
							nxt.valid_rings = sat_cnt(cur.valid_rings);
							judged_valid    = 1'b1;
						end else begin
							nxt.valid_rings = '0;
						end
						nxt.phase      = PH_LOW;
						nxt.low_count  = CNT_BITS'(1);
						nxt.high_count = '0;
					end
				end
				default: ;
			endcase
			nxt.prev_level = sample.line_level;
			if (judged_valid && (CMP_W'(nxt.valid_rings) == CMP_W'(cfg.ring_target))) begin
				result.status = ST_FOUND;
				nxt.phase     = PH_IDLE;
			end else if (nxt.elapsed >= cfg.window_ticks) begin
				result.status = ST_TIMEOUT;
				nxt.phase     = PH_IDLE;
			end
			result.ring_tally = 8'(nxt.valid_rings);
		end
	end

endmodule

FILE: rtl/rcd_out_buf.sv
// Two-entry result buffer between the detector state and the result channel.
`timescale 1ns / 1ps
module rcd_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rcd_pkg::rcd_result_t push_item,
	output logic                 full,
	output logic                 result_valid,
	input  logic                 result_stall,
	output rcd_pkg::rcd_result_t result
);
	import rcd_pkg::*;

	logic        head_v_q;
	logic        skid_v_q;
	rcd_result_t head_q;
	rcd_result_t skid_q;
	logic        pop;

	assign pop          = head_v_q && !result_stall;
	assign full         = skid_v_q;
	assign result_valid = head_v_q;
	assign result       = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else if (!push) begin
					head_v_q <= 1'b0;
				end
			end else if (push) begin
				if (!head_v_q) begin
					head_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= push_item;
			end
		end else if (push) begin
			if (!head_v_q) begin
				head_q <= push_item;
			end else begin
				skid_q <= push_item;
			end
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> head_v_q)
		else $error("skid entry held without head entry");
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("item pushed into full buffer");
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> head_v_q)
		else $error("pushed item lost");
	a_held_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(head_v_q && result_stall) |=> (head_v_q && $stable(head_q)))
		else $error("stalled item dropped or changed");
`endif

endmodule

FILE: rtl/ring_cadence_detector_unit.sv
// Ring cadence detector top level: config registers, session state, result buffer.
// Results: each result is registered in the result buffer and offered on the result channel from its head entry.
// Throughput: one sample per cycle while sample_stall is low; rcd_step computes the next state combinationally.
// A two-entry result buffer takes one more sample while a result waits, then stalls input.
// Reset: registers return to their defaults, the session is idle, the buffer is empty.
`timescale 1ns / 1ps
module ring_cadence_detector_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  rcd_pkg::rcd_sample_t               sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output rcd_pkg::rcd_result_t               result,
	input  logic                               cfg_we,
	input  logic [rcd_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rcd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rcd_pkg::*;

	rcd_cfg_t    cfg_q;
	rcd_state_t  state_q;
	rcd_state_t  state_nxt;
	rcd_result_t step_result;
	logic        take;
	logic        buf_full;

	assign sample_stall = buf_full;
	assign take         = sample_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_LOW_MIN:      cfg_q.low_min      <= cfg_data[7:0];
				CFG_LOW_MAX:      cfg_q.low_max      <= cfg_data[7:0];
				CFG_HIGH_MIN:     cfg_q.high_min     <= cfg_data[7:0];
				CFG_HIGH_MAX:     cfg_q.high_max     <= cfg_data[7:0];
				CFG_RING_TARGET:  cfg_q.ring_target  <= cfg_data[7:0];
				CFG_WINDOW_TICKS: cfg_q.window_ticks <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rcd_step u_step (
		.cfg    (cfg_q),
		.cur    (state_q),
		.sample (sample),
		.nxt    (state_nxt),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	rcd_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (take),
		.push_item    (step_result),
		.full         (buf_full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && sample.restart) |=> (state_q.phase == PH_WAIT && state_q.elapsed == '0
			&& state_q.valid_rings == '0))
		else $error("restart did not clear the session");
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !sample.restart && state_q.phase == PH_IDLE) |=> state_q.phase == PH_IDLE)
		else $error("idle session left without restart");
	a_report_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (step_result.status == ST_FOUND || step_result.status == ST_TIMEOUT))
		|=> state_q.phase == PH_IDLE)
		else $error("report not followed by idle");
`endif

endmodule

FILE: sim/rcd_checker.sv
// Checker for the ring cadence detector: tracks config writes, predicts each result, compares.
`timescale 1ns / 1ps
module rcd_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	input  logic                           sample_stall,
	input  rcd_pkg::rcd_sample_t           sample,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  rcd_pkg::rcd_result_t           result,
	input  logic                           cfg_we,
	input  logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             outstanding,
	output logic                           session_open
);
	import rcd_pkg::*;

	rcd_cfg_t              regs;
	rcd_phase_t            phase;
	logic                  prev_level;
	logic [CNT_BITS-1:0]   low_run;
	logic [CNT_BITS-1:0]   high_run;
	logic [CNT_BITS-1:0]   tally;
	logic [ELAPSED_W-1:0]  ticks;
	rcd_result_t           tick_reports[$];
	rcd_result_t           want;

	function automatic rcd_result_t judge_sample(input rcd_sample_t s);
		rcd_result_t r;
		logic        judged;
		judged       = 1'b0;
		r.status     = ST_SEARCH;
		r.ring_tally = '0;
		if (s.restart) begin
			phase      = PH_WAIT;
			low_run    = '0;
			high_run   = '0;
			tally      = '0;
			ticks      = '0;
			prev_level = s.line_level;
			return r;
		end
		if (phase == PH_IDLE) begin
			prev_level   = s.line_level;
			r.status     = ST_IDLE;
			r.ring_tally = tally;
			return r;
		end
		if (ticks != ELAPSED_MAX)
			ticks = ticks + 1'b1;
		case (phase)
			PH_WAIT: begin
				if (prev_level && !s.line_level) begin
					phase    = PH_LOW;
					low_run  = CNT_BITS'(1);
					high_run = '0;
				end
			end
			PH_LOW: begin
				if (!s.line_level) begin
					if (low_run != CNT_MAX)
						low_run = low_run + 1'b1;
				end else if (low_run >= regs.low_min && low_run <= regs.low_max) begin
					phase    = PH_HIGH;
					high_run = CNT_BITS'(1);
				end else begin
					tally = '0;
					phase = PH_WAIT;
				end
			end
			default: begin
				if (s.line_level) begin
					if (high_run != CNT_MAX)
						high_run = high_run + 1'b1;
				end else begin
					if (high_run >= regs.high_min && high_run <= regs.high_max) begin
						if (tally != CNT_MAX)
							tally = tally + 1'b1;
						judged = 1'b1;
					end else begin
						tally = '0;
					end
					phase    = PH_LOW;
					low_run  = CNT_BITS'(1);
					high_run = '0;
				end
			end
		endcase
		prev_level = s.line_level;
		if (judged && tally == regs.ring_target) begin
			r.status = ST_FOUND;
			phase    = PH_IDLE;
		end else if (ticks >= regs.window_ticks) begin
			r.status = ST_TIMEOUT;
			phase    = PH_IDLE;
		end
		r.ring_tally = tally;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs         = CFG_RESET;
			phase        = PH_IDLE;
			prev_level   = 1'b1;
			low_run      = '0;
			high_run     = '0;
			tally        = '0;
			ticks        = '0;
			fail_count   = 0;
			tick_reports.delete();
			outstanding  <= 0;
			session_open <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (tick_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("rcd_checker: unexpected result status %0d tally %0d",
							result.status, result.ring_tally);
				end else begin
					want = tick_reports.pop_front();
					if (want.status !== result.status || want.ring_tally !== result.ring_tally) begin
						fail_count++;
						if (fail_count <= 10)
							$display("rcd_checker: expected status %0d tally %0d, got status %0d tally %0d",
								want.status, want.ring_tally, result.status, result.ring_tally);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_LOW_MIN:      regs.low_min      = cfg_data[7:0];
					CFG_LOW_MAX:      regs.low_max      = cfg_data[7:0];
					CFG_HIGH_MIN:     regs.high_min     = cfg_data[7:0];
					CFG_HIGH_MAX:     regs.high_max     = cfg_data[7:0];
					CFG_RING_TARGET:  regs.ring_target  = cfg_data[7:0];
					CFG_WINDOW_TICKS: regs.window_ticks = cfg_data[15:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall)
				tick_reports.push_back(judge_sample(sample));
			outstanding  <= tick_reports.size();
			session_open <= (phase != PH_IDLE);
		end
	end

endmodule

FILE: sim/testbench.sv
// Testbench top for the ring cadence detector: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 1ps
module testbench;
	import rcd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 64;

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	rcd_sample_t           sample;
	logic                  result_valid;
	logic                  result_stall;
	rcd_result_t           result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    outstanding;
	logic                  session_open;
	rcd_cfg_t              cur_cfg;
	bit                    tx_quiet;
	bit                    rx_quiet;
	bit                    hold_req;
	bit                    hold_done;
	int                    live_items;
	int                    quiet_cycles;

	ring_cadence_detector_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data)
	);

	rcd_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.session_open (session_open)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			result_stall <= !rx_quiet && ($urandom_range(99) < 18);
		end
	end

	task automatic put_reg(input rcd_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic set_cfg(input rcd_cfg_t c);
		put_reg(CFG_LOW_MIN, {8'd0, c.low_min});
		put_reg(CFG_LOW_MAX, {8'd0, c.low_max});
		put_reg(CFG_HIGH_MIN, {8'd0, c.high_min});
		put_reg(CFG_HIGH_MAX, {8'd0, c.high_max});
		put_reg(CFG_RING_TARGET, {8'd0, c.ring_target});
		put_reg(CFG_WINDOW_TICKS, c.window_ticks);
		cfg_we  <= 1'b0;
		cur_cfg = c;
	endtask

	function automatic rcd_cfg_t random_cfg();
		rcd_cfg_t c;
		c.low_min      = 8'($urandom_range(4, 0));
		c.low_max      = c.low_min + 8'($urandom_range(3, 0));
		c.high_min     = 8'($urandom_range(5, 1));
		c.high_max     = c.high_min + 8'($urandom_range(3, 0));
		c.ring_target  = 8'($urandom_range(4, 1));
		c.window_ticks = 16'($urandom_range(90, 15));
		return c;
	endfunction

	function automatic int pick_len(input logic [7:0] lo, input logic [7:0] hi);
		int r;
		r = $urandom_range(99);
		if (lo > hi)
			return $urandom_range(6, 1);
		if (r < 76)
			return (hi == 0) ? 1 : $urandom_range(hi, (lo == 0) ? 1 : lo);
		if (r < 88 && lo > 1)
			return lo - 1;
		return (hi < 255) ? hi + 1 : hi;
	endfunction

	task automatic push_sample(input logic lvl, input logic rst);
		if (!tx_quiet) begin
			while ($urandom_range(99) < 18) begin
				sample_valid <= 1'b0;
				@(posedge clk);
			end
		end
		sample_valid <= 1'b1;
		sample       <= '{line_level: lvl, restart: rst};
		if (session_open)
			live_items++;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic random_phase(input int budget);
		int stop_at;
		int burst;
		int gap;
		stop_at = live_items + budget;
		while (live_items < stop_at) begin
			push_sample($urandom_range(9) != 0, 1'b1);
			do begin
				if ($urandom_range(99) < 8) begin
					push_sample(1'($urandom_range(1)), $urandom_range(19) == 0);
				end else begin
					burst = pick_len(cur_cfg.low_min, cur_cfg.low_max);
					gap   = pick_len(cur_cfg.high_min, cur_cfg.high_max);
					repeat (burst) push_sample(1'b0, 1'b0);
					repeat (gap) push_sample(1'b1, 1'b0);
				end
			end while (session_open && live_items < stop_at);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		sample_valid <= 1'b0;
		sample       <= '0;
		cfg_we       <= 1'b0;
		cfg_idx      <= CFG_LOW_MIN;
		cfg_data     <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_cfg('{low_min: 8'd1, low_max: 8'd2, high_min: 8'd1, high_max: 8'd2,
			ring_target: 8'd2, window_ticks: 16'd5});
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		push_sample(1'b1, 1'b1);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		push_sample(1'b1, 1'b1);
		repeat (3) push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		push_sample(1'b1, 1'b0);
		settle();

		set_cfg('{low_min: 8'd1, low_max: 8'd2, high_min: 8'd1, high_max: 8'd2,
			ring_target: 8'd0, window_ticks: 16'd4});
		push_sample(1'b1, 1'b1);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		settle();

		set_cfg('{low_min: 8'd1, low_max: 8'd3, high_min: 8'd200, high_max: 8'd100,
			ring_target: 8'd255, window_ticks: 16'd8});
		push_sample(1'b0, 1'b1);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		push_sample(1'b1, 1'b0);
		push_sample(1'b0, 1'b0);
		settle();

		set_cfg('{low_min: 8'd9, low_max: 8'd2, high_min: 8'd0, high_max: 8'd255,
			ring_target: 8'd1, window_ticks: 16'd0});
		push_sample(1'b1, 1'b1);
		push_sample(1'b1, 1'b0);
		settle();

		set_cfg(random_cfg());
		random_phase(50);
		settle();

		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		set_cfg(random_cfg());
		random_phase(50);
		settle();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		set_cfg(random_cfg());
		hold_req = 1'b1;
		random_phase(50);
		settle();

		set_cfg(random_cfg());
		random_phase(50);
		settle();

		// drive the low count into saturation; only a saturated burst lands in the window
		set_cfg('{low_min: 8'd255, low_max: 8'd255, high_min: 8'd1, high_max: 8'd255,
			ring_target: 8'd1, window_ticks: 16'd65535});
		push_sample(1'b1, 1'b1);
		repeat (258) push_sample(1'b0, 1'b0);
		repeat (3) push_sample(1'b1, 1'b0);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);
		settle();

		if (fail_count == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
